@@ hw/rtl/rtcb_pkg.sv @@
// Package for the RTC burst I2C master: command codes, bus phases, BCD helpers.
// No dependencies.
package rtcb_pkg;

  localparam int unsigned BurstBytes = 8;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_LOAD  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_COPY  = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_DONE   = 4'd1,
    PH_RSTART = 4'd2,
    PH_SHIGH  = 4'd3,
    PH_SLOW   = 4'd4,
    PH_SFALL  = 4'd5,
    PH_BSET   = 4'd6,
    PH_BHIGH  = 4'd7,
    PH_BFALL  = 4'd8,
    PH_PSET   = 4'd9,
    PH_PHIGH  = 4'd10
  } phase_e;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StBusy = 2'd1;
  localparam logic [1:0] StRead = 2'd2;
  localparam logic [1:0] StWrite = 2'd3;

  localparam logic [1:0] RegAddr = 2'd0;
  localparam logic [1:0] RegCtrl = 2'd1;
  localparam logic [1:0] RegRefresh = 2'd2;

  // One accepted item, formed combinationally from the input ports.
  typedef struct packed {
    logic [2:0] cmd;
    logic       sda;
    logic [2:0] fidx;
    logic [6:0] fval;
  } item_t;

  // Binary 0..127 to tens/units byte, tens (up to 12) in the upper nibble.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [3:0] t;
    logic [6:0] r;
    begin
      // simple compare chain: at most 12 tens
      t = 4'd0;
      if (v >= 7'd120) t = 4'd12; else if (v >= 7'd110) t = 4'd11;
      else if (v >= 7'd100) t = 4'd10; else if (v >= 7'd90) t = 4'd9;
      else if (v >= 7'd80) t = 4'd8; else if (v >= 7'd70) t = 4'd7;
      else if (v >= 7'd60) t = 4'd6; else if (v >= 7'd50) t = 4'd5;
      else if (v >= 7'd40) t = 4'd4; else if (v >= 7'd30) t = 4'd3;
      else if (v >= 7'd20) t = 4'd2; else if (v >= 7'd10) t = 4'd1;
      r = v - 7'(t) * 7'd10;
      return {t, r[3:0]};
    end
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] v, input logic [3:0] tmask);
    logic [3:0] t;
    begin
      t = v[7:4] & tmask;
      return 8'({4'd0, v[3:0]} + 8'(t) * 8'd10);
    end
  endfunction

endpackage

@@ hw/rtl/rtcb_engine.sv @@
// Bus sequencer and buffers of the RTC burst master; one item per cycle.
// Depends on rtcb_pkg.
module rtcb_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_en_i,
  input  rtcb_pkg::item_t    item_i,
  input  logic [6:0]         dev_addr_i,
  input  logic [7:0]         ctrl_byte_i,
  input  logic [15:0]        period_i,
  output logic               scl_o,
  output logic               pull_o,
  output logic [1:0]         status_o,
  output logic               ack_o,
  output logic               pulse_o,
  output logic [7:0]         rb_o [rtcb_pkg::BurstBytes]
);
  import rtcb_pkg::*;

  logic [7:0]  wb_q [BurstBytes-1];
  logic [7:0]  wb_d [BurstBytes-1];
  logic [7:0]  rb_q [BurstBytes];
  logic [7:0]  rb_d [BurstBytes];
  phase_e      ph_q, ph_d;
  logic        rd_q, rd_d;
  logic [3:0]  bit_q, bit_d, byte_q, byte_d;
  logic [7:0]  sh_q, sh_d, last_q, last_d;
  logic [15:0] cnt_q, cnt_d;
  logic        ack_q, ack_d;
  logic        pulse;

  // load the shift register for the byte indexed by b
  function automatic logic [7:0] byte_for(input logic rd, input logic [3:0] b,
                                          input logic [6:0] a, input logic [7:0] c,
                                          input logic [7:0] w [BurstBytes-1]);
    begin
      if (rd) return (b == 4'd0) ? {a, 1'b0} : (b == 4'd2) ? {a, 1'b1} : 8'd0;
      else if (b == 4'd0) return {a, 1'b0};
      else if (b == 4'd1) return 8'd0;
      else if (b < 4'(BurstBytes + 1)) return w[3'(b - 4'd2)];
      else return c;
    end
  endfunction

  logic tx;
  logic busy;
  assign tx = !(rd_q && byte_q >= 4'd3);
  assign busy = !(ph_q == PH_IDLE || ph_q == PH_DONE);

  // next state of the sequencer and buffers
  always_comb begin
    logic [7:0] shifted;
    wb_d = wb_q; rb_d = rb_q; ph_d = ph_q; rd_d = rd_q; bit_d = bit_q;
    byte_d = byte_q; sh_d = sh_q; last_d = last_q; cnt_d = cnt_q; ack_d = ack_q;
    pulse = 1'b0;
    shifted = {sh_q[6:0], item_i.sda};
    if (item_en_i) begin
      if (item_i.cmd == CMD_TICK) begin
        case (ph_q)
          PH_IDLE, PH_DONE: begin
            if (period_i != 16'd0) begin
              if (cnt_q <= 16'd1) begin
                cnt_d = period_i;
                ph_d = PH_SHIGH; rd_d = 1'b1; byte_d = '0; bit_d = '0;
                sh_d = '0; ack_d = 1'b0;
              end else cnt_d = cnt_q - 16'd1;
            end
          end
          PH_RSTART: ph_d = PH_SHIGH;
          PH_SHIGH:  ph_d = PH_SLOW;
          PH_SLOW:   ph_d = PH_SFALL;
          PH_SFALL: begin
            sh_d = byte_for(rd_q, byte_q, dev_addr_i, ctrl_byte_i, wb_q);
            bit_d = '0; ph_d = PH_BSET;
          end
          PH_BSET: ph_d = PH_BHIGH;
          PH_BHIGH: begin
            if (bit_q < 4'd8) begin
              if (!tx) begin
                sh_d = shifted;
                if (bit_q == 4'd7 && byte_q >= 4'd3) rb_d[3'(byte_q - 4'd3)] = shifted;
              end
            end else if (tx && item_i.sda) ack_d = 1'b1;
            ph_d = PH_BFALL;
          end
          PH_BFALL: begin
            if (bit_q < 4'd8) begin
              if (tx) sh_d = {sh_q[6:0], 1'b0};
              bit_d = bit_q + 4'd1; ph_d = PH_BSET;
            end else begin
              byte_d = byte_q + 4'd1;
              if (rd_q && byte_d == 4'd2) ph_d = PH_RSTART;
              else if (byte_d < (rd_q ? 4'(BurstBytes + 3) : 4'(BurstBytes + 2))) begin
                sh_d = byte_for(rd_q, byte_d, dev_addr_i, ctrl_byte_i, wb_q);
                bit_d = '0; ph_d = PH_BSET;
              end else ph_d = PH_PSET;
            end
          end
          PH_PSET: ph_d = PH_PHIGH;
          PH_PHIGH: begin
            ph_d = PH_DONE;
            if (rd_q && from_bcd(rb_q[0], 4'hF) != last_q) begin
              last_d = from_bcd(rb_q[0], 4'hF); pulse = 1'b1;
            end
          end
          default: ph_d = PH_IDLE;
        endcase
      end else if (!busy) begin
        case (item_i.cmd)
          CMD_LOAD: if (item_i.fidx != 3'd7) wb_d[item_i.fidx] = to_bcd(item_i.fval);
          CMD_WRITE, CMD_READ: begin
            ph_d = PH_SHIGH; rd_d = (item_i.cmd == CMD_READ); byte_d = '0;
            bit_d = '0; sh_d = '0; ack_d = 1'b0;
          end
          CMD_COPY: for (int k = 0; k < BurstBytes - 1; k++) wb_d[k] = rb_q[k];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < BurstBytes - 1; k++) wb_q[k] <= '0;
      for (int k = 0; k < BurstBytes; k++) rb_q[k] <= '0;
      ph_q <= PH_IDLE; rd_q <= 1'b0; bit_q <= '0; byte_q <= '0; sh_q <= '0;
      cnt_q <= 16'd1; last_q <= 8'hFF; ack_q <= 1'b0; pulse_o <= 1'b0;
    end else begin
      wb_q <= wb_d; rb_q <= rb_d; ph_q <= ph_d; rd_q <= rd_d; bit_q <= bit_d;
      byte_q <= byte_d; sh_q <= sh_d; cnt_q <= cnt_d; last_q <= last_d;
      ack_q <= ack_d;
      if (item_en_i) pulse_o <= pulse;
    end
  end

  // line levels and status from the registered state
  logic data_low;
  always_comb begin
    if (bit_q < 4'd8) data_low = tx && !sh_q[7];
    else if (tx) data_low = 1'b0;
    else data_low = (byte_q < 4'(BurstBytes + 2));
    scl_o = (ph_q == PH_IDLE || ph_q == PH_DONE || ph_q == PH_SHIGH ||
             ph_q == PH_SLOW || ph_q == PH_BHIGH || ph_q == PH_PHIGH);
    case (ph_q)
      PH_SLOW, PH_SFALL, PH_PSET, PH_PHIGH: pull_o = 1'b1;
      PH_BSET, PH_BHIGH, PH_BFALL:          pull_o = data_low;
      default:                              pull_o = 1'b0;
    endcase
    status_o = (ph_q == PH_IDLE) ? StIdle : (ph_q == PH_DONE) ?
               (rd_q ? StRead : StWrite) : StBusy;
  end

  assign ack_o = ack_q;
  assign rb_o = rb_q;
endmodule

@@ hw/rtl/i2c_rtc_burst_master.sv @@
// Top level of the RTC burst I2C master: handshakes, config registers, outputs.
// Depends on rtcb_pkg and rtcb_engine.
//
// Usage: every input transfer is either a tick (one bus delay slot, with the
// sampled SDA level) or a command (load field, start write, start read, copy).
// Each accepted item yields exactly one result transfer carrying SCL level,
// SDA pull-low, status, ack flag, second-changed pulse and decoded time.
// The engine state register updates at the accept edge and the result is
// shown from the cycle after the accept on. One item per cycle is
// taken while the output is free or being taken in the same cycle; in_stall_o
// is high only while a result waits and out_stall_i is high.
// Configuration writes (index 0 address, 1 control byte, 2 refresh period)
// are always ready and are meant to happen while the block is idle.
// Reset clears the sequencer to idle, buffers to zero, refresh counter to one,
// and drops out_valid_o. When the receiver stalls, the result holds and new
// items wait on in_stall_o.
module i2c_rtc_burst_master (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] cmd_i,
  input  logic       sda_in_i,
  input  logic [2:0] field_index_i,
  input  logic [6:0] field_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_level_o,
  output logic       sda_pull_low_o,
  output logic [1:0] status_o,
  output logic       ack_missing_o,
  output logic       second_changed_o,
  output logic [7:0] seconds_o,
  output logic [7:0] minutes_o,
  output logic [5:0] hours_o,
  output logic [2:0] weekday_o,
  output logic [5:0] date_o,
  output logic [4:0] month_o,
  output logic [7:0] year_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import rtcb_pkg::*;

  logic [6:0]  addr_q;
  logic [7:0]  ctrl_q;
  logic [15:0] per_q;
  logic        ov_q;
  logic        take;
  item_t       item;
  logic [7:0]  rb [8];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = ov_q && out_stall_i;
  assign take = in_valid_i && !in_stall_o;
  assign item = '{cmd: cmd_i, sda: sda_in_i, fidx: field_index_i, fval: field_value_i};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= 7'd104; ctrl_q <= 8'h13; per_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegAddr:    addr_q <= cfg_data_i[6:0];
        RegCtrl:    ctrl_q <= cfg_data_i[7:0];
        RegRefresh: per_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (take) ov_q <= 1'b1;
    else if (!out_stall_i) ov_q <= 1'b0;
  end

  rtcb_engine u_engine (
    .clk_i, .rst_ni, .item_en_i(take), .item_i(item),
    .dev_addr_i(addr_q), .ctrl_byte_i(ctrl_q), .period_i(per_q),
    .scl_o(scl_level_o), .pull_o(sda_pull_low_o), .status_o(status_o),
    .ack_o(ack_missing_o), .pulse_o(second_changed_o), .rb_o(rb)
  );

  assign out_valid_o = ov_q;
  assign seconds_o = from_bcd(rb[0], 4'hF);
  assign minutes_o = from_bcd(rb[1], 4'hF);
  assign hours_o   = 6'(from_bcd(rb[2], 4'h3));
  assign weekday_o = rb[3][2:0];
  assign date_o    = 6'(from_bcd(rb[4], 4'h3));
  assign month_o   = 5'(from_bcd(rb[5], 4'h1));
  assign year_o    = from_bcd(rb[6], 4'hF);
endmodule

@@ hw/rtl/rtcb_checker.sv @@
// Port-level checker for the RTC burst master, bound to the top level.
// Depends on rtcb_pkg and the top-level ports.
module rtcb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       scl_level_o,
  input logic [1:0] status_o,
  input logic       second_changed_o
);
  // an accepted item always produces a result
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o) else $error("missing result");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  // clock line released whenever not busy
  a_scl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != rtcb_pkg::StBusy |-> scl_level_o)
    else $error("scl low idle");
  // second pulse only at end of read
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && second_changed_o |-> status_o == rtcb_pkg::StRead)
    else $error("bad pulse");
endmodule

bind i2c_rtc_burst_master rtcb_checker u_checker (.*);
